[src/cwwb_pkg.sv]
`timescale 1ns / 1ps

package cwwb_pkg;

    localparam int COORD_BITS     = 11;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int WINDOW_HALF    = 40;

    localparam int PIX_BITS   = 8;
    localparam int SUM_BITS   = 21;
    localparam int GAIN_BITS  = 16;
    localparam int CFG_BITS   = 12;
    localparam int CHANNELS   = 3;
    localparam int CH_BITS    = 2;
    localparam int STEP_BITS  = $clog2(GAIN_BITS);
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = PIX_BITS + GAIN_BITS;
    localparam int NUM_BITS   = SUM_BITS + GAIN_BITS;
    localparam int SIZE_LIMIT = 1 << COORD_BITS;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(160);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(120);

    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = '1;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY =
        (GAIN_FRAC_BITS >= GAIN_BITS) ? GAIN_MAX : GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [PIX_BITS-1:0]  PIX_MAX    = '1;

    typedef struct packed {
        logic               pix;
        logic               pick;
        logic               load;
        logic               step;
        logic               last;
        logic               clear;
        logic [CH_BITS-1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic fend;
        logic out_free;
        logic skip;
        logic sat;
    } t_status;

    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return SIZE_BITS'(1);
        end else if (v32 > 32'(SIZE_LIMIT)) begin
            return SIZE_BITS'(SIZE_LIMIT);
        end
        return SIZE_BITS'(v32);
    endfunction

    function automatic logic in_window(input logic [COORD_BITS-1:0] pos,
                                       input logic [SIZE_BITS-1:0]  size);
        logic [31:0] half;
        logic [31:0] first;
        logic [31:0] last;
        half  = 32'(size) >> 1;
        first = (half > 32'(WINDOW_HALF)) ? half - 32'(WINDOW_HALF) : 32'd0;
        last  = (half + 32'(WINDOW_HALF) >= 32'(size)) ? 32'(size)
                                                       : half + 32'(WINDOW_HALF);
        return (32'(pos) >= first) && (32'(pos) < last);
    endfunction

endpackage

[src/cwwb_ctrl.sv]
`timescale 1ns / 1ps

module cwwb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_measure,
    input  cwwb_pkg::t_status i_status,
    output logic              o_s_tready,
    output cwwb_pkg::t_cmd    o_cmd
);
    import cwwb_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PICK,
        ST_LOAD,
        ST_STEP
    } t_state;

    t_state                r_state, n_state;
    logic [CH_BITS-1:0]    r_chan, n_chan;
    logic [STEP_BITS-1:0]  r_cnt, n_cnt;
    logic                  accept;
    logic                  chan_last;
    logic                  step_last;

    assign o_s_tready = (r_state == ST_RUN) && i_status.out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign chan_last  = (r_chan == CH_BITS'(CHANNELS - 1));
    assign step_last  = (r_cnt == STEP_BITS'(GAIN_BITS - 1));

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.chan = r_chan;
        case (r_state)
            ST_RUN: begin
                o_cmd.pix = accept;
                if (accept && i_status.fend && i_measure) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_chan     = '0;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                if (i_status.skip || i_status.sat) begin
                    if (chan_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_RUN;
                    end else begin
                        n_chan = r_chan + CH_BITS'(1);
                    end
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                o_cmd.last = step_last;
                n_cnt      = r_cnt + STEP_BITS'(1);
                if (step_last) begin
                    if (chan_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_RUN;
                    end else begin
                        n_chan  = r_chan + CH_BITS'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_chan  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[src/cwwb_datapath.sv]
`timescale 1ns / 1ps

module cwwb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cwwb_pkg::t_cmd                      i_cmd,
    output cwwb_pkg::t_status                   o_status,
    input  logic                                i_cfg_valid,
    input  logic [cwwb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [cwwb_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic [cwwb_pkg::PIX_BITS-1:0]       i_pix [cwwb_pkg::CHANNELS],
    input  logic                                i_measure,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [cwwb_pkg::PIX_BITS-1:0]       o_pix [cwwb_pkg::CHANNELS],
    output logic                                o_frame_end,
    output logic                                o_gains_updated
);
    import cwwb_pkg::*;

    logic [CFG_BITS-1:0]   r_frame_width;
    logic [CFG_BITS-1:0]   r_frame_height;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] r_col;
    logic [SUM_BITS-1:0]   r_sum  [CHANNELS];
    logic [GAIN_BITS-1:0]  r_gain [CHANNELS];
    logic                  r_out_valid;
    logic [PIX_BITS-1:0]   r_out_pix [CHANNELS];
    logic                  r_out_fend;
    logic                  r_out_upd;

    logic [SUM_BITS-1:0]   r_mx;
    logic [CH_BITS-1:0]    r_max_idx;
    logic                  r_all_zero;
    logic [SUM_BITS-1:0]   r_rem;
    logic [GAIN_BITS-1:0]  r_low;
    logic [SUM_BITS-1:0]   r_den;
    logic [GAIN_BITS-1:0]  r_quo;

    logic [SIZE_BITS-1:0]  w_eff;
    logic [SIZE_BITS-1:0]  h_eff;
    logic                  inwin;
    logic                  row_end;
    logic                  fend;
    logic [PIX_BITS-1:0]   bal   [CHANNELS];
    logic [SUM_BITS-1:0]   acc   [CHANNELS];
    logic [PROD_BITS-1:0]  prod  [CHANNELS];
    logic [PROD_BITS-1:0]  shr   [CHANNELS];
    logic [SUM_BITS:0]     wide  [CHANNELS];
    logic [CH_BITS-1:0]    max_idx;
    logic [NUM_BITS-1:0]   num;
    logic [SUM_BITS-1:0]   den;
    logic [SUM_BITS:0]     trial;
    logic                  ge;
    logic [SUM_BITS-1:0]   n_rem;
    logic [GAIN_BITS-1:0]  n_quo;

    assign w_eff   = eff_size(r_frame_width);
    assign h_eff   = eff_size(r_frame_height);
    assign inwin   = in_window(r_row, h_eff) && in_window(r_col, w_eff);
    assign row_end = SIZE_BITS'(r_col) >= (w_eff - SIZE_BITS'(1));
    assign fend    = row_end && (SIZE_BITS'(r_row) >= (h_eff - SIZE_BITS'(1)));

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            prod[k] = PROD_BITS'(i_pix[k]) * PROD_BITS'(r_gain[k]);
            shr[k]  = prod[k] >> GAIN_FRAC_BITS;
            bal[k]  = (shr[k] > PROD_BITS'(PIX_MAX)) ? PIX_MAX : shr[k][PIX_BITS-1:0];
            wide[k] = {1'b0, r_sum[k]} + (SUM_BITS + 1)'(bal[k]);
            acc[k]  = wide[k][SUM_BITS] ? {SUM_BITS{1'b1}} : wide[k][SUM_BITS-1:0];
        end
    end

    // largest sum, ties to the lower channel
    always_comb begin
        if (r_sum[0] >= r_sum[1] && r_sum[0] >= r_sum[2]) begin
            max_idx = CH_BITS'(0);
        end else if (r_sum[1] >= r_sum[2]) begin
            max_idx = CH_BITS'(1);
        end else begin
            max_idx = CH_BITS'(2);
        end
    end

    assign den   = r_sum[i_cmd.chan];
    assign num   = NUM_BITS'(r_mx) << GAIN_FRAC_BITS;
    assign trial = {r_rem, r_low[GAIN_BITS-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? SUM_BITS'(trial - {1'b0, r_den}) : SUM_BITS'(trial);
    assign n_quo = {r_quo[GAIN_BITS-2:0], ge};

    assign o_status.fend     = fend;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_status.skip     = r_all_zero || (i_cmd.chan == r_max_idx);
    assign o_status.sat      = num[NUM_BITS-1:GAIN_BITS] >= den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_row          <= '0;
            r_col          <= '0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_sum[k]  <= '0;
                r_gain[k] <= GAIN_UNITY;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.pix) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.pix) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (fend && !i_measure) begin
                        r_sum[k] <= '0;
                    end else if (inwin) begin
                        r_sum[k] <= acc[k];
                    end
                end
                if (fend) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + COORD_BITS'(1);
                end else begin
                    r_col <= r_col + COORD_BITS'(1);
                end
            end

            if (i_cmd.load) begin
                if (o_status.skip) begin
                    r_gain[i_cmd.chan] <= GAIN_UNITY;
                end else if (o_status.sat) begin
                    r_gain[i_cmd.chan] <= GAIN_MAX;
                end
            end
            if (i_cmd.step && i_cmd.last) begin
                r_gain[i_cmd.chan] <= n_quo;
            end

            if (i_cmd.clear) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    r_sum[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix) begin
            r_out_pix  <= bal;
            r_out_fend <= fend;
            r_out_upd  <= fend && i_measure;
        end
        if (i_cmd.pick) begin
            r_mx       <= r_sum[max_idx];
            r_max_idx  <= max_idx;
            r_all_zero <= (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0);
        end
        if (i_cmd.load) begin
            r_rem <= num[NUM_BITS-1:GAIN_BITS];
            r_low <= num[GAIN_BITS-1:0];
            r_den <= den;
            r_quo <= '0;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_low <= {r_low[GAIN_BITS-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_pix           = r_out_pix;
    assign o_frame_end     = r_out_fend;
    assign o_gains_updated = r_out_upd;

endmodule

[src/center_window_white_balance.sv]
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// s         in         i_s_tvalid/o_s_tready   tdata chan0..2, tuser measure_frame
// m         out        o_m_tvalid/i_m_tready   tdata chan0..2, tlast frame_end,
//                                              tuser gains_updated
// cfg       in         i_cfg_valid/o_cfg_ready index 0 frame_width, 1 frame_height
//
// one pixel per cycle while not stalled; each result sits in an output register from the next cycle
// a measured frame end holds s_tready low for a pick, a load per
// channel and 16 divider steps for each other channel whose quotient fits
// synchronous active-low reset: gains 1.0, sums and position zero
// otherwise the input stalls only while the output register holds an untaken item

module center_window_white_balance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [23:0]                       i_s_tdata,   // chan0_in, chan1_in, chan2_in
    input  logic                              i_s_tuser,   // measure_frame
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [23:0]                       o_m_tdata,   // chan0_out, chan1_out, chan2_out
    output logic                              o_m_tlast,
    output logic                              o_m_tuser,   // gains_updated
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cwwb_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [cwwb_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import cwwb_pkg::*;

    t_cmd                cmd;
    t_status             status;
    logic [PIX_BITS-1:0] pix_in  [CHANNELS];
    logic [PIX_BITS-1:0] pix_out [CHANNELS];
    logic                s_accept;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;

    assign pix_in[0] = i_s_tdata[7:0];
    assign pix_in[1] = i_s_tdata[15:8];
    assign pix_in[2] = i_s_tdata[23:16];
    assign o_m_tdata = {pix_out[2], pix_out[1], pix_out[0]};

    cwwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_measure  (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    cwwb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pix           (pix_in),
        .i_measure       (i_s_tuser),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_pix           (pix_out),
        .o_frame_end     (o_m_tlast),
        .o_gains_updated (o_m_tuser)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> (!o_m_tvalid || i_m_tready))
        else $error("item accepted over an untaken result");

    a_upd_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("gain update flagged away from frame end");

    a_stall_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser && status.fend) |=> !o_s_tready)
        else $error("input taken during gain update");

    a_update_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && status.fend) |=> (o_m_tvalid && o_m_tlast
                                       && (o_m_tuser == $past(i_s_tuser))))
        else $error("frame end result mismatch");

endmodule
